// ----- design/vpl_pkg.sv -----
package vpl_pkg;

	// fraction bits of the parametric coordinates and weights
	localparam int FRAC_BITS = 16;
	localparam int PC_W      = 24;
	// quotient bits produced by the divider, one above the saturation range
	localparam int QW        = PC_W + 1;
	localparam int DIV_STEP  = 5;
	localparam int DIV_ITERS = QW / DIV_STEP;
	localparam int PRE_SHIFT = QW - FRAC_BITS;
	localparam int W_W       = FRAC_BITS + 1;
	localparam int DIST_W    = 63;

	localparam logic signed [PC_W-1:0] PC_MAX = {1'b0, {(PC_W-1){1'b1}}};
	localparam logic signed [PC_W-1:0] PC_MIN = {1'b1, {(PC_W-1){1'b0}}};

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_SIZE_X   = 3'd3,
		REG_SIZE_Y   = 3'd4,
		REG_SIZE_Z   = 3'd5
	} vpl_reg_t;

	typedef struct packed {
		logic [2:0][31:0] origin;
		logic [2:0][30:0] size;
	} vpl_cfg_t;

	// one located point, handed from the front to the back
	typedef struct packed {
		logic                  in_box;
		logic [2:0][PC_W-1:0]  pc;
		logic [2:0][31:0]      cl;
		logic [2:0][31:0]      m;
		logic                  msat;
	} vpl_entry_t;

endpackage

// ----- design/voxel_point_locate_trilinear_unit.sv -----
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+----------------------------------------
// s_*       | in        | s_tvalid / s_tready        | s_tdata: px, py, pz
// m_*       | out       | m_tvalid / m_tready        | m_tdata, m_tuser (inside_res), m_tlast
// apb       | in        | psel, penable, pwrite      | paddr, pwdata, prdata, pready (always 1)
//
// a query passes through the front in order: offset, setup, the radix-32 divider
// producing 25 quotient bits per axis, then the handoff to the queue
// the front can take a new request into its input stage while the divider is busy;
// the back issues one result per cycle while the output is not stalled and the queue
// is not empty: 8 results for a point inside, 1 for a point outside
// results pass the s1, s2 and output registers after issue; a 2-deep queue splits front from back
// m_tready low stalls only the back; the front keeps working until the queue fills
// reset clears all handshake state; registers return to origin 0, size 1.0
module voxel_point_locate_trilinear_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	// apb configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// query points
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // px[31:0], py[63:32], pz[95:64]
	// results
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata,   // r[23:0], s[47:24], t[71:48], closest_x[103:72],
	                                // closest_y[135:104], closest_z[167:136],
	                                // dist_sq[230:168], corner_index[233:231],
	                                // weight[250:234], zero fill
	output logic [0:0]   m_tuser,   // inside_res
	output logic         m_tlast
);
	import vpl_pkg::*;

	vpl_cfg_t   cfg_q;
	vpl_reg_t   reg_idx;
	vpl_entry_t push_data, head;
	logic       push, full, head_valid, pop;
	logic [2:0][31:0] pt;

	logic                  o_inside, o_last;
	logic [2:0][PC_W-1:0]  o_pc;
	logic [2:0][31:0]      o_cl;
	logic [DIST_W-1:0]     o_dist;
	logic [2:0]            o_corner;
	logic [W_W-1:0]        o_weight;

	// register file, written in the access phase
	assign pready  = 1'b1;
	assign reg_idx = vpl_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin <= '0;
			for (int a = 0; a < 3; a++) cfg_q.size[a] <= 31'(65536);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_ORIGIN_X: cfg_q.origin[0] <= pwdata;
				REG_ORIGIN_Y: cfg_q.origin[1] <= pwdata;
				REG_ORIGIN_Z: cfg_q.origin[2] <= pwdata;
				REG_SIZE_X:   cfg_q.size[0]   <= pwdata[30:0];
				REG_SIZE_Y:   cfg_q.size[1]   <= pwdata[30:0];
				REG_SIZE_Z:   cfg_q.size[2]   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ORIGIN_X: prdata = cfg_q.origin[0];
			REG_ORIGIN_Y: prdata = cfg_q.origin[1];
			REG_ORIGIN_Z: prdata = cfg_q.origin[2];
			REG_SIZE_X:   prdata = {1'b0, cfg_q.size[0]};
			REG_SIZE_Y:   prdata = {1'b0, cfg_q.size[1]};
			REG_SIZE_Z:   prdata = {1'b0, cfg_q.size[2]};
			default:      prdata = '0;
		endcase
	end

	assign pt[0] = s_tdata[31:0];
	assign pt[1] = s_tdata[63:32];
	assign pt[2] = s_tdata[95:64];

	// front: offset, inside test, clamping and division
	vpl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.pt       (pt),
		.q_push   (push),
		.q_data   (push_data),
		.q_full   (full)
	);

	vpl_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.valid  (head_valid),
		.rdata  (head)
	);

	// back: weights per corner, squared distance, output register
	vpl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_inside (o_inside),
		.out_pc     (o_pc),
		.out_cl     (o_cl),
		.out_dist   (o_dist),
		.out_corner (o_corner),
		.out_weight (o_weight),
		.out_last   (o_last)
	);

	assign m_tdata = {5'd0, o_weight, o_corner, o_dist, o_cl[2], o_cl[1], o_cl[0],
	                  o_pc[2], o_pc[1], o_pc[0]};
	assign m_tuser = o_inside;
	assign m_tlast = o_last;

	// an outside result is a single one with no weight
	a_outside_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && o_corner == 3'd0 && o_weight == '0)
		else $error("outside result not a lone weightless result");

	// an inside run ends exactly at the last corner
	a_inside_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tlast == (o_corner == 3'd7)) && o_dist == '0)
		else $error("inside run framing or distance wrong");

	// consecutive inside results of one run step through the corners
	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser[0] && !m_tlast ##1 m_tvalid
		|-> m_tuser[0] && o_corner == $past(o_corner) + 3'd1)
		else $error("corner sequence broken");

endmodule

// ----- design/vpl_front.sv -----
module vpl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  vpl_pkg::vpl_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0][31:0]  pt,
	output logic              q_push,
	output vpl_pkg::vpl_entry_t q_data,
	input  logic              q_full
);
	import vpl_pkg::*;

	typedef enum logic [1:0] {IDLE, PREP, ITER, DONE} state_t;

	state_t state_q;

	logic                    s1_valid_q;
	logic [2:0][31:0]        p_s1;
	logic [2:0][32:0]        d_s1;

	logic [2:0][31:0]        p_q;
	logic [2:0]              neg_q;
	logic [2:0][32:0]        mag_q;
	logic [2:0][30:0]        rem_q;
	logic [2:0][QW-1:0]      num_q;
	logic [2:0][QW-1:0]      quo_q;
	logic [2:0]              ovf_q;
	logic                    in_q;
	logic [2:0][31:0]        cl_q;
	logic [2:0][31:0]        m_q;
	logic                    msat_q;
	logic [2:0]              cnt_q;

	logic                    div_free;
	logic [2:0][30:0]        sz;
	logic [2:0][30:0]        rem_nx;
	logic [2:0][DIV_STEP-1:0] qb_nx;
	logic                    any_out;
	logic                    any_msat;

	assign div_free = (state_q == IDLE) || (state_q == DONE && !q_full);
	assign in_ready = !s1_valid_q || div_free;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sz[a] = (cfg.size[a] == '0) ? 31'd1 : cfg.size[a];
		end
	end

	// any axis off the box, and any offset too large to square
	always_comb begin
		any_out  = 1'b0;
		any_msat = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (neg_q[a]) begin
				any_out = 1'b1;
				if (mag_q[a][32]) any_msat = 1'b1;
			end else if (mag_q[a] > {2'b0, sz[a]}) begin
				any_out = 1'b1;
			end
		end
	end

	// input stage: offset from the voxel origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int a = 0; a < 3; a++) begin
				p_s1[a] <= pt[a];
				d_s1[a] <= {pt[a][31], pt[a]} - {cfg.origin[a][31], cfg.origin[a]};
			end
		end
	end

	// restoring division, several quotient bits per cycle
	always_comb begin
		logic [31:0] t;
		logic [30:0] r;
		for (int a = 0; a < 3; a++) begin
			r = rem_q[a];
			qb_nx[a] = '0;
			for (int j = 0; j < DIV_STEP; j++) begin
				t = {r, num_q[a][QW-1-j]};
				if (t >= {1'b0, sz[a]}) begin
					t = t - {1'b0, sz[a]};
					qb_nx[a][DIV_STEP-1-j] = 1'b1;
				end
				r = t[30:0];
			end
			rem_nx[a] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				IDLE, DONE: begin
					if (div_free) begin
						state_q <= s1_valid_q ? PREP : IDLE;
						for (int a = 0; a < 3; a++) begin
							p_q[a]   <= p_s1[a];
							neg_q[a] <= d_s1[a][32];
							mag_q[a] <= d_s1[a][32] ? (33'd0 - d_s1[a]) : d_s1[a];
						end
					end
				end
				PREP: begin
					state_q <= ITER;
					cnt_q   <= '0;
					in_q    <= !any_out;
					msat_q  <= any_msat;
					for (int a = 0; a < 3; a++) begin
						ovf_q[a] <= {8'd0, mag_q[a]} >= {1'b0, sz[a], {PRE_SHIFT{1'b0}}};
						rem_q[a] <= 31'(mag_q[a] >> PRE_SHIFT);
						num_q[a] <= {mag_q[a][PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
						if (neg_q[a]) begin
							cl_q[a] <= cfg.origin[a];
							m_q[a]  <= mag_q[a][31:0];
						end else if (mag_q[a] > {2'b0, sz[a]}) begin
							cl_q[a] <= cfg.origin[a] + {1'b0, sz[a]};
							m_q[a]  <= 32'(mag_q[a] - {2'b0, sz[a]});
						end else begin
							cl_q[a] <= p_q[a];
							m_q[a]  <= '0;
						end
					end
				end
				ITER: begin
					for (int a = 0; a < 3; a++) begin
						rem_q[a] <= rem_nx[a];
						num_q[a] <= num_q[a] << DIV_STEP;
						quo_q[a] <= {quo_q[a][QW-DIV_STEP-1:0], qb_nx[a]};
					end
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'(DIV_ITERS - 1)) state_q <= DONE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// saturate the quotient to the signed parametric range
	always_comb begin
		q_data.in_box = in_q;
		q_data.msat   = msat_q;
		for (int a = 0; a < 3; a++) begin
			q_data.cl[a] = cl_q[a];
			q_data.m[a]  = m_q[a];
			if (neg_q[a]) begin
				if (ovf_q[a] || quo_q[a] > {1'b0, PC_MAX} + QW'(1)) q_data.pc[a] = PC_MIN;
				else q_data.pc[a] = PC_W'(QW'(0) - quo_q[a]);
			end else begin
				if (ovf_q[a] || quo_q[a] > {1'b0, PC_MAX}) q_data.pc[a] = PC_MAX;
				else q_data.pc[a] = quo_q[a][PC_W-1:0];
			end
		end
	end

	assign q_push = (state_q == DONE) && !q_full;

endmodule

// ----- design/vpl_fifo.sv -----
module vpl_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vpl_pkg::vpl_entry_t wdata,
	output logic                full,
	input  logic                pop,
	output logic                valid,
	output vpl_pkg::vpl_entry_t rdata
);
	import vpl_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	vpl_entry_t           mem_q [DEPTH];
	logic [AW-1:0]        wr_q, rd_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;

	assign full  = cnt_q == ($clog2(DEPTH+1))'(DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- design/vpl_back.sv -----
module vpl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  vpl_pkg::vpl_entry_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_inside,
	output logic [2:0][vpl_pkg::PC_W-1:0] out_pc,
	output logic [2:0][31:0]    out_cl,
	output logic [vpl_pkg::DIST_W-1:0] out_dist,
	output logic [2:0]          out_corner,
	output logic [vpl_pkg::W_W-1:0] out_weight,
	output logic                out_last
);
	import vpl_pkg::*;

	localparam logic [W_W-1:0] ONE  = W_W'(1) << FRAC_BITS;
	localparam int             HALF = 1 << (FRAC_BITS - 1);

	logic                 en, issue, last_k;
	logic [2:0]           k_q;
	logic [W_W-1:0]       a, b, c;

	logic                 v_s1, v_s2;
	logic                 in_s1, in_s2, last_s1, last_s2, sat_s1;
	logic [2:0]           k_s1, k_s2;
	logic [2:0][PC_W-1:0] pc_s1, pc_s2;
	logic [2:0][31:0]     cl_s1, cl_s2;
	logic [2*W_W-1:0]     ab_s1, abc_s2;
	logic [W_W-1:0]       c_s1;
	logic [2:0][63:0]     sq_s1;
	logic [DIST_W-1:0]    dist_s2;

	logic [2*W_W:0]       ab_rnd, abc_rnd;
	logic [W_W-1:0]       w1;
	logic [65:0]          dsum;

	assign en     = !out_valid || out_ready;
	assign issue  = en && head_valid;
	assign last_k = !head.in_box || (k_q == 3'd7);
	assign pop    = issue && last_k;

	// corner k takes r or 1-r by bit 0, s by bit 1, t by bit 2
	assign a = k_q[0] ? W_W'(head.pc[0]) : ONE - W_W'(head.pc[0]);
	assign b = k_q[1] ? W_W'(head.pc[1]) : ONE - W_W'(head.pc[1]);
	assign c = k_q[2] ? W_W'(head.pc[2]) : ONE - W_W'(head.pc[2]);

	assign ab_rnd  = {1'b0, ab_s1} + (2*W_W+1)'(HALF);
	assign w1      = ab_rnd[FRAC_BITS +: W_W];
	assign abc_rnd = {1'b0, abc_s2} + (2*W_W+1)'(HALF);
	assign dsum    = {2'b0, sq_s1[0]} + {2'b0, sq_s1[1]} + {2'b0, sq_s1[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			if (issue) k_q <= last_k ? 3'd0 : k_q + 3'd1;
			v_s1      <= head_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1   <= head.in_box;
			last_s1 <= last_k;
			k_s1    <= head.in_box ? k_q : 3'd0;
			pc_s1   <= head.pc;
			cl_s1   <= head.cl;
			sat_s1  <= head.msat;
			ab_s1   <= a * b;
			c_s1    <= c;
			for (int i = 0; i < 3; i++) sq_s1[i] <= head.m[i] * head.m[i];

			in_s2   <= in_s1;
			last_s2 <= last_s1;
			k_s2    <= k_s1;
			pc_s2   <= pc_s1;
			cl_s2   <= cl_s1;
			abc_s2  <= w1 * c_s1;
			if (sat_s1 || dsum[65:DIST_W] != '0) dist_s2 <= '1;
			else dist_s2 <= dsum[DIST_W-1:0];

			out_inside <= in_s2;
			out_last   <= last_s2;
			out_corner <= k_s2;
			out_pc     <= pc_s2;
			out_cl     <= cl_s2;
			out_dist   <= in_s2 ? '0 : dist_s2;
			if (!in_s2) out_weight <= '0;
			else if (abc_rnd[2*W_W:FRAC_BITS+W_W] != '0) out_weight <= '1;
			else out_weight <= abc_rnd[FRAC_BITS +: W_W];
		end
	end

endmodule

// ----- sim/tb_voxel_point_locate_trilinear_unit.sv -----
`timescale 1ns / 100ps

module tb_voxel_point_locate_trilinear_unit;
	import vpl_pkg::*;

	// one query point as it travels on s_tdata
	typedef struct packed {
		logic [31:0] pz;
		logic [31:0] py;
		logic [31:0] px;
	} point_t;

	// one result, unpacked from m_tdata, m_tuser and m_tlast
	typedef struct {
		logic        in_box;
		logic [23:0] pc [3];
		logic [31:0] cl [3];
		logic [62:0] dist_sq;
		logic [2:0]  corner;
		logic [16:0] weight;
		logic        last;
	} locate_res_t;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [255:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tlast;

	voxel_point_locate_trilinear_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// voxel registers as the predictor sees them
	longint      vox_org [3];
	longint      vox_size [3];

	point_t      pending_pts [$];
	locate_res_t expected_res [$];
	int          fail_cnt;
	int          idle_cycles;
	int          src_idle_pct;
	int          dst_stall_pct;
	int          hold_off;
	bit          src_pause;
	bit          s_acc;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// parametric coordinate: truncated division, saturated to 24 bits
	function automatic longint param_coord(longint d, longint sz);
		longint q;
		q = ((d < 0 ? -d : d) << FRAC_BITS) / sz;
		if (d < 0)
			return (q > 64'sd8388608) ? -64'sd8388608 : -q;
		return (q > 64'sd8388607) ? 64'sd8388607 : q;
	endfunction

	function automatic longint round_mul(longint a, longint b);
		return (a * b + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	// works out the results of one query and queues them
	function automatic void locate_point(point_t pt);
		longint      p [3], d [3], pc [3], sz [3], cl [3], w, m;
		logic [63:0] msq, dist_acc;
		locate_res_t r;
		bit          is_in;
		is_in = 1'b1;
		p[0] = longint'($signed(pt.px));
		p[1] = longint'($signed(pt.py));
		p[2] = longint'($signed(pt.pz));
		for (int i = 0; i < 3; i++) begin
			sz[i] = (vox_size[i] == 0) ? 1 : vox_size[i];
			d[i] = p[i] - vox_org[i];
			pc[i] = param_coord(d[i], sz[i]);
			if (d[i] < 0 || d[i] > sz[i])
				is_in = 1'b0;
			r.pc[i] = pc[i][23:0];
		end
		r.in_box = is_in;
		if (is_in) begin
			for (int k = 0; k < 8; k++) begin
				w = round_mul(round_mul(k[0] ? pc[0] : 65536 - pc[0],
					k[1] ? pc[1] : 65536 - pc[1]), k[2] ? pc[2] : 65536 - pc[2]);
				if (w > 'h1FFFF)
					w = 'h1FFFF;
				for (int i = 0; i < 3; i++)
					r.cl[i] = p[i][31:0];
				r.dist_sq = '0;
				r.corner = k[2:0];
				r.weight = w[16:0];
				r.last = (k == 7);
				expected_res.push_back(r);
			end
		end else begin
			dist_acc = 0;
			for (int i = 0; i < 3; i++) begin
				if (d[i] < 0)
					cl[i] = vox_org[i];
				else if (d[i] > sz[i])
					cl[i] = vox_org[i] + sz[i];
				else
					cl[i] = p[i];
				m = (p[i] >= cl[i]) ? p[i] - cl[i] : cl[i] - p[i];
				msq = 64'(m) * 64'(m);
				if (m > 'hFFFFFFFF || msq > 64'h7FFFFFFFFFFFFFFF
						|| dist_acc > 64'h7FFFFFFFFFFFFFFF - msq)
					dist_acc = 64'h7FFFFFFFFFFFFFFF;
				else
					dist_acc = dist_acc + msq;
				r.cl[i] = cl[i][31:0];
			end
			r.dist_sq = dist_acc[62:0];
			r.corner = '0;
			r.weight = '0;
			r.last = 1'b1;
			expected_res.push_back(r);
		end
	endfunction

	// request accepted at the last rising edge
	always @(posedge clk) begin
		s_acc <= arst_n && s_tvalid && s_tready;
	end

	// driver: requests leave the queue only when accepted
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_acc) begin
				locate_point(point_t'(s_tdata));
				void'(pending_pts.pop_front());
			end
			// keep offering while the current request waits, otherwise pick the next
			if (!(s_tvalid && !s_acc)) begin
				if (pending_pts.size() > 0 && !src_pause
						&& $urandom_range(99) >= src_idle_pct) begin
					s_tdata  <= pending_pts[0];
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off counted here
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= dst_stall_pct);
		end
	end

	// monitor: compare each result against the oldest expectation
	always @(posedge clk) begin
		locate_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_res.size() == 0) begin
				$display("%0t: result with nothing expected, tdata %h", $realtime, m_tdata);
				fail_cnt++;
			end else begin
				e = expected_res.pop_front();
				if (m_tuser[0] !== e.in_box || m_tdata[23:0] !== e.pc[0]
						|| m_tdata[47:24] !== e.pc[1] || m_tdata[71:48] !== e.pc[2]
						|| m_tdata[103:72] !== e.cl[0] || m_tdata[135:104] !== e.cl[1]
						|| m_tdata[167:136] !== e.cl[2] || m_tdata[230:168] !== e.dist_sq
						|| m_tdata[233:231] !== e.corner || m_tdata[250:234] !== e.weight
						|| m_tlast !== e.last) begin
					$display("%0t: mismatch expected in=%b r=%h s=%h t=%h cl=%h %h %h d=%h k=%0d w=%h l=%b",
						$realtime, e.in_box, e.pc[0], e.pc[1], e.pc[2], e.cl[0], e.cl[1],
						e.cl[2], e.dist_sq, e.corner, e.weight, e.last);
					$display("%0t:          actual   in=%b r=%h s=%h t=%h cl=%h %h %h d=%h k=%0d w=%h l=%b",
						$realtime, m_tuser[0], m_tdata[23:0], m_tdata[47:24], m_tdata[71:48],
						m_tdata[103:72], m_tdata[135:104], m_tdata[167:136], m_tdata[230:168],
						m_tdata[233:231], m_tdata[250:234], m_tlast);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("voxel_point_locate_trilinear_unit test failed");
			$finish;
		end
	end

	// register write: setup then access cycle, block idle
	task automatic write_reg(vpl_reg_t idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx <= REG_ORIGIN_Z)
			vox_org[idx] = longint'($signed(val));
		else
			vox_size[idx - REG_SIZE_X] = val & 32'h7FFFFFFF;
	endtask

	task automatic set_voxel(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
	endtask

	// wait until every request went in and every result came out
	task automatic drain();
		while (pending_pts.size() > 0 || s_tvalid || expected_res.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// coordinate along one axis: mostly inside or just around the box
	function automatic logic [31:0] pick_coord(int ax);
		longint v;
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'(vox_org[ax]);
			2: return 32'(vox_org[ax] + vox_size[ax]);
			3: return 32'(vox_org[ax] - $urandom_range(65536));
			4: return 32'(vox_org[ax] + vox_size[ax] + $urandom_range(65536));
			default: begin
				v = vox_org[ax] + longint'($urandom) % (vox_size[ax] + 1);
				return v[31:0];
			end
		endcase
	endfunction

	// random phase: queue points around the current voxel
	task automatic random_phase(int n);
		point_t pt;
		for (int j = 0; j < n; j++) begin
			pt.px = pick_coord(0);
			pt.py = pick_coord(1);
			pt.pz = pick_coord(2);
			pending_pts.push_back(pt);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		fail_cnt = 0;
		idle_cycles = 0;
		hold_off = 0;
		src_pause = 1'b0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		for (int i = 0; i < 3; i++) begin
			vox_org[i] = 0;
			vox_size[i] = 65536;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset voxel, corners, center, field extremes, far points
		pending_pts.push_back('{32'h0, 32'h0, 32'h0});
		pending_pts.push_back('{32'h10000, 32'h10000, 32'h10000});
		pending_pts.push_back('{32'h8000, 32'h4000, 32'hC000});
		pending_pts.push_back('{32'h10000, 32'h0, 32'h8000});
		pending_pts.push_back('{32'h10001, 32'h8000, 32'h8000});
		pending_pts.push_back('{32'hFFFFFFFF, 32'h8000, 32'h8000});
		pending_pts.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
		pending_pts.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
		pending_pts.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h5555AAAA});
		pending_pts.push_back('{32'hAAAA5555, 32'h80000000, 32'h7FFFFFFF});
		drain();

		// tiny voxel with zero size: parametric saturation and one-lsb box
		set_voxel(32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1, 32'h0);
		pending_pts.push_back('{32'h0, 32'h80000000, 32'h7FFFFFFF});
		pending_pts.push_back('{32'h1, 32'h80000001, 32'h7FFFFFFF});
		pending_pts.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000});
		pending_pts.push_back('{32'h80000000, 32'h80000002, 32'h7FFFFFFE});
		drain();

		// largest voxel, origin at the bottom, high bits masked
		set_voxel(32'h80000000, 32'h80000000, 32'h80000000,
			32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		pending_pts.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
		pending_pts.push_back('{32'h0, 32'h80000000, 32'h40000000});
		pending_pts.push_back('{32'hFFFFFFFF, 32'hC0000000, 32'h12345678});
		drain();

		// random phases over several voxels and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
				1: begin src_idle_pct = 45; dst_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  dst_stall_pct = 45; end
				default: begin src_idle_pct = 13; dst_stall_pct = 13; end
			endcase
			case (ph)
				0: set_voxel(32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000);
				1: set_voxel($urandom, $urandom, $urandom, $urandom_range(1, 32'hFFFFF),
					$urandom_range(1, 32'hFFFFF), $urandom_range(1, 32'hFFFFF));
				2: set_voxel(32'hFFF00000, 32'h00100000, 32'h0, 32'h300000, 32'h3, 32'h7FFFFFFF);
				3: set_voxel($urandom_range(32'h1000000), 32'hFFFF0000, 32'h80000000,
					32'h20000, 32'h8000, 32'h40000000);
				default: set_voxel(32'(-$urandom_range(32'h100000)), $urandom_range(32'h100000),
					32'(-$urandom_range(32'h1000)), $urandom_range(1, 32'h80000),
					$urandom_range(1, 32'h80000), $urandom_range(1, 32'h80000));
			endcase
			if (ph == 2)
				hold_off = 400;
			random_phase(55);
			drain();
		end

		// sender pause: points are queued while the sender holds off, then released
		src_pause = 1'b1;
		random_phase(10);
		repeat (30) @(posedge clk);
		src_pause = 1'b0;
		drain();

		if (fail_cnt == 0)
			$display("voxel_point_locate_trilinear_unit test passed");
		else
			$display("voxel_point_locate_trilinear_unit test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/vpl_pkg.sv
design/vpl_front.sv
design/vpl_fifo.sv
design/vpl_back.sv
design/voxel_point_locate_trilinear_unit.sv
sim/tb_voxel_point_locate_trilinear_unit.sv
